// ----- rtl/core/ppwm_pkg.sv -----
// ----------------------------------------------------------------------------
// ppwm_pkg
// Widths, round constants, the prime table and the per-stage record used by
// the prime product word mixer.
// ----------------------------------------------------------------------------
package ppwm_pkg;

  localparam int WORD_W     = 64;
  localparam int HALF_W     = 32;
  localparam int NUM_ROUNDS = 64;
  localparam int NUM_PRIMES = 2 * NUM_ROUNDS;

  localparam logic [5:0] SRC_ROT = 6'd13;

  localparam logic [WORD_W-1:0] ACC_INIT = 64'd1;

  localparam logic [WORD_W-1:0] PRIME_TABLE [NUM_PRIMES] = '{
    64'd2985113428254948959, 64'd2133371973447287789, 64'd9566925003104080411,
    64'd6083414080430737261, 64'd3191658566037706763, 64'd6913367267901031997,
    64'd3051762490125913007, 64'd4496279044463191703, 64'd2879325911889076339,
    64'd1685450054146532617, 64'd3665492224534333199, 64'd5457405118009752311,
    64'd9603674174905975319, 64'd5115570615370213399, 64'd2085406057152991381,
    64'd3944123521248288751, 64'd7068318273059084621, 64'd9757209530458778617,
    64'd4605875306346355289, 64'd6173263078309968247, 64'd7762991333463966857,
    64'd9020426977113888977, 64'd7479023155365493211, 64'd1106308364738794853,
    64'd6407388572493574733, 64'd2575377960084637447, 64'd3570804859728957167,
    64'd9744215084471400349, 64'd5786617550671126231, 64'd3349473746601511027,
    64'd4095923646587284861, 64'd9337574612835542873, 64'd3860411135543820653,
    64'd6490253556739218821, 64'd8764900392399904901, 64'd3339372363887497583,
    64'd6577701767928311429, 64'd9172672799009443051, 64'd2788564470716716463,
    64'd7776210437768060567, 64'd9071396938031495159, 64'd5357072389526583433,
    64'd6633238451589839561, 64'd6234713344370965483, 64'd1756087432259377561,
    64'd3210111471103586737, 64'd2408295824875360559, 64'd8027800137025286071,
    64'd1345382896972678691, 64'd9079595888451204607, 64'd6556450002823963531,
    64'd7301373103704944939, 64'd1213337252585919101, 64'd8574942160927332881,
    64'd8566185364500201241, 64'd6910045784078487233, 64'd2298581249625702883,
    64'd2596136803677419831, 64'd8990581036371057601, 64'd3046889204803159003,
    64'd6864701819024214703, 64'd9142639517683050829, 64'd3257525145999184439,
    64'd5916350576516314903, 64'd1991008946812235681, 64'd5221054210441722691,
    64'd4658950185140640559, 64'd7616154792906075869, 64'd3789735489826889479,
    64'd6040491638497194979, 64'd4531551599015040559, 64'd8347022247974757701,
    64'd5867558032219360441, 64'd4346307676337591453, 64'd1905346606445378533,
    64'd7219759323757378847, 64'd8561163821217102983, 64'd6227762971465314193,
    64'd1778354250598502561, 64'd5435722899178511549, 64'd7859180386742822047,
    64'd3610133528213982527, 64'd4577787558750808879, 64'd3974497005134013109,
    64'd3241288686894948329, 64'd3206546850542044487, 64'd2621128575668534623,
    64'd6945339563322422683, 64'd2086055779082649859, 64'd9237096783908108657,
    64'd1916568609042647407, 64'd8362781431934621017, 64'd6122543372115730003,
    64'd6200399818195771541, 64'd1259180073496439959, 64'd4347405785030416513,
    64'd4385862544209720253, 64'd5836562284002027449, 64'd3121678407354608831,
    64'd4319136453194505203, 64'd9085838656424873461, 64'd5448516463713100871,
    64'd4520015808866767003, 64'd2892328915328607301, 64'd3897908110284010777,
    64'd6252018905800065119, 64'd3278710975885668139, 64'd2623408458547857527,
    64'd3055342605008846819, 64'd5255646576194862401, 64'd5611094629836787733,
    64'd3296996236992951511, 64'd3283558997806116761, 64'd2823396471863459119,
    64'd9572308265712226037, 64'd8290430615658140401, 64'd2621246478142939039,
    64'd1300291691995934101, 64'd1143863624227711889, 64'd6789671898597272039,
    64'd1593529243588418053, 64'd6573565795099723367, 64'd7154224095543629129,
    64'd2355509713379653547, 64'd7691022839137400143, 64'd2727794217173953619,
    64'd8541344794240933387, 64'd6490328854741497349
  };

  // one stage of a round: product is built up in phi/plo over three stages
  typedef struct packed {
    logic [WORD_W-1:0] src;
    logic [WORD_W-1:0] sink;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [HALF_W-1:0] phi;
    logic [HALF_W-1:0] plo;
  } rnd_t;

  function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v,
                                               input logic [5:0] n);
    logic [6:0] rn;
    rn = 7'd64 - {1'b0, n};
    if (n == 6'd0) begin
      return v;
    end
    return (v << n) | (v >> rn);
  endfunction

endpackage

// ----- rtl/core/prime_product_word_mixer.sv -----
// ----------------------------------------------------------------------------
// prime_product_word_mixer
// 64-round multiply-rotate mixer of a source word into a sink word.
// Each round has three registered stages (A, B, C), followed by one output
// register. Throughput: one transaction per cycle unless the output stalls.
// The whole pipeline holds while a result waits on out_stall.
// Reset clears the valid bits only; no data state is kept between words.
// ----------------------------------------------------------------------------
module prime_product_word_mixer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ppwm_pkg::WORD_W-1:0]  in_source_word,
  input  logic [ppwm_pkg::WORD_W-1:0]  in_sink_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ppwm_pkg::WORD_W-1:0]  out_mixed_word
);
  import ppwm_pkg::*;

  logic adv;

  rnd_t stg_a_r [NUM_ROUNDS];
  rnd_t stg_b_r [NUM_ROUNDS];
  rnd_t stg_c_r [NUM_ROUNDS];
  logic vld_a_r [NUM_ROUNDS];
  logic vld_b_r [NUM_ROUNDS];
  logic vld_c_r [NUM_ROUNDS];

  logic              out_valid_r;
  logic [WORD_W-1:0] out_mixed_word_r;
  logic [WORD_W-1:0] out_mixed_word_nxt;
  logic [WORD_W-1:0] acc_last;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_rnd
    localparam logic [WORD_W-1:0] P_EVEN = PRIME_TABLE[2*g];
    localparam logic [WORD_W-1:0] P_ODD  = PRIME_TABLE[2*g+1];

    logic [WORD_W-1:0] src_prev;
    logic [WORD_W-1:0] acc_prev;
    logic [WORD_W-1:0] sink_prev;
    logic              vld_prev;
    logic [WORD_W-1:0] lo_prod;
    logic [HALF_W-1:0] cross_b;
    logic [HALF_W-1:0] cross_c;
    rnd_t              stg_a_nxt;
    rnd_t              stg_b_nxt;
    rnd_t              stg_c_nxt;

    if (g == 0) begin : g_first
      assign src_prev  = in_source_word;
      assign acc_prev  = ACC_INIT;
      assign sink_prev = in_sink_word;
      assign vld_prev  = in_valid;
    end else begin : g_next
      assign src_prev  = stg_c_r[g-1].src;
      assign acc_prev  = {stg_c_r[g-1].phi, stg_c_r[g-1].plo};
      // previous round's sink contribution
      assign sink_prev = stg_c_r[g-1].sink + (acc_prev ^ src_prev);
      assign vld_prev  = vld_c_r[g-1];
    end

    // stage A: rotates, prime select, low x low product
    always_comb begin
      stg_a_nxt      = '0;
      stg_a_nxt.src  = rotl64(src_prev, SRC_ROT);
      stg_a_nxt.sink = sink_prev;
      stg_a_nxt.a    = rotl64(acc_prev, 6'(g));
      stg_a_nxt.b    = stg_a_nxt.src[0] ? P_ODD : P_EVEN;
      lo_prod        = stg_a_nxt.a[HALF_W-1:0] * stg_a_nxt.b[HALF_W-1:0];
      stg_a_nxt.phi  = lo_prod[WORD_W-1:HALF_W];
      stg_a_nxt.plo  = lo_prod[HALF_W-1:0];
    end

    // stage B: a_lo x b_hi cross term
    always_comb begin
      stg_b_nxt     = stg_a_r[g];
      cross_b       = stg_a_r[g].a[HALF_W-1:0] * stg_a_r[g].b[WORD_W-1:HALF_W];
      stg_b_nxt.phi = stg_a_r[g].phi + cross_b;
    end

    // stage C: a_hi x b_lo cross term
    always_comb begin
      stg_c_nxt     = stg_b_r[g];
      cross_c       = stg_b_r[g].a[WORD_W-1:HALF_W] * stg_b_r[g].b[HALF_W-1:0];
      stg_c_nxt.phi = stg_b_r[g].phi + cross_c;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_a_r[g] <= 1'b0;
        vld_b_r[g] <= 1'b0;
        vld_c_r[g] <= 1'b0;
      end else if (adv) begin
        vld_a_r[g] <= vld_prev;
        vld_b_r[g] <= vld_a_r[g];
        vld_c_r[g] <= vld_b_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg_a_r[g] <= stg_a_nxt;
        stg_b_r[g] <= stg_b_nxt;
        stg_c_r[g] <= stg_c_nxt;
      end
    end
  end

  assign acc_last = {stg_c_r[NUM_ROUNDS-1].phi, stg_c_r[NUM_ROUNDS-1].plo};

  always_comb begin
    out_mixed_word_nxt = (stg_c_r[NUM_ROUNDS-1].sink
                          + (acc_last ^ stg_c_r[NUM_ROUNDS-1].src)) ^ acc_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_c_r[NUM_ROUNDS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_mixed_word_r <= out_mixed_word_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mixed_word = out_mixed_word_r;

  // accepted transaction enters the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_a_r[0])
    else $error("accepted transaction missing from first stage");

  // first round works on an accumulator of one
  a_first_acc: assert property (@(posedge clk) disable iff (!rst_n)
    vld_a_r[0] |-> (stg_a_r[0].a == ACC_INIT))
    else $error("first round accumulator not one");

  // pipeline tail frozen while the result is held
  a_hold_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(vld_c_r[NUM_ROUNDS-1])
                                  && $stable(stg_c_r[NUM_ROUNDS-1])))
    else $error("pipeline moved during output stall");

endmodule

// ----- sim/prime_product_word_mixer_tb.sv -----
// ----------------------------------------------------------------------------
// prime_product_word_mixer_tb
// Self-checking bench for the prime product word mixer. Each accepted input
// transaction is run through a local 64-round mix predictor and the word it
// yields is queued. Every output transaction is compared in order against
// that queue. The stimulus is a directed set of edge words followed by
// random words under three idling mixes on both channels. One long receiver
// hold-off fills the pipeline, and the sender pauses until the pipeline has
// drained.
// ----------------------------------------------------------------------------
module prime_product_word_mixer_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import ppwm_pkg::*;

  localparam int          PHASE_WORDS    = 400;
  localparam int          LONG_HOLD      = 600;
  localparam int          DRAIN_CYCLES   = 250;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  class word_mixer_scoreboard;
    logic [WORD_W-1:0] expected_words [$];
    int unsigned       error_count;

    function new();
      error_count = 0;
    endfunction

    static function logic [WORD_W-1:0] rotate_left(logic [WORD_W-1:0] v, int unsigned n);
      if (n == 0) begin
        return v;
      end
      return (v << n) | (v >> (WORD_W - n));
    endfunction

    static function logic [WORD_W-1:0] mix_word(logic [WORD_W-1:0] source,
                                                logic [WORD_W-1:0] sink);
      logic [WORD_W-1:0] src;
      logic [WORD_W-1:0] acc;
      logic [WORD_W-1:0] sum;
      src = source;
      sum = sink;
      acc = ACC_INIT;
      for (int r = 0; r < NUM_ROUNDS; r++) begin
        src = rotate_left(src, 13);
        acc = rotate_left(acc, r);
        acc = acc * PRIME_TABLE[2 * r + int'(src[0])];
        sum = sum + (acc ^ src);
      end
      return sum ^ acc;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
    endtask

    function void note_input(logic [WORD_W-1:0] source, logic [WORD_W-1:0] sink);
      expected_words.push_back(mix_word(source, sink));
    endfunction

    task check_result(logic [WORD_W-1:0] mixed);
      logic [WORD_W-1:0] want;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected result %h", mixed));
      end else begin
        want = expected_words.pop_front();
        if (mixed !== want) begin
          report($sformatf("mixed_word got %h want %h", mixed, want));
        end
      end
    endtask
  endclass

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic [WORD_W-1:0] in_source_word = '0;
  logic [WORD_W-1:0] in_sink_word   = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic [WORD_W-1:0] out_mixed_word;

  int          sender_idle_pct   = 11;
  int          receiver_idle_pct = 73;
  logic        hold_toggle       = 1'b0;
  logic        hold_seen         = 1'b0;
  int          hold_count        = 0;
  int unsigned quiet_cycles      = 0;

  word_mixer_scoreboard sb = new();

  prime_product_word_mixer u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_source_word (in_source_word),
    .in_sink_word   (in_sink_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_mixed_word (out_mixed_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver back-pressure, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen  <= hold_toggle;
      hold_count <= LONG_HOLD;
      out_stall  <= 1'b1;
    end else if (hold_count > 0) begin
      hold_count <= hold_count - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_mixed_word);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drive_word(logic [WORD_W-1:0] source, logic [WORD_W-1:0] sink);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_source_word <= source;
    in_sink_word   <= sink;
    do begin
      @(posedge clk);
    end while (in_stall);
    sb.note_input(source, sink);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_words.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [WORD_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [WORD_W-1:0] shaped_source();
    logic [WORD_W-1:0] one_hot;
    one_hot = 64'd1 << $urandom_range(63);
    case ($urandom_range(9))
      0:       return one_hot;
      1:       return ~one_hot;
      2:       return random_word() & random_word() & random_word();
      default: return random_word();
    endcase
  endfunction

  task automatic random_phase(int src_idle, int rcv_idle);
    sender_idle_pct   <= src_idle;
    receiver_idle_pct <= rcv_idle;
    for (int i = 0; i < PHASE_WORDS; i++) begin
      drive_word(shaped_source(), random_word());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed edge words
    drive_word(64'h0, 64'h0);
    drive_word({WORD_W{1'b1}}, {WORD_W{1'b1}});
    drive_word(64'h0, {WORD_W{1'b1}});
    drive_word({WORD_W{1'b1}}, 64'h0);
    drive_word(64'h1, 64'h0);
    drive_word(64'h8000_0000_0000_0000, 64'h0);
    drive_word(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    drive_word(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    drive_word(64'h0000_0000_0000_2000, 64'h1);
    drive_word(64'h0008_0000_0000_0000, 64'h8000_0000_0000_0000);
    drive_word(64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000);
    drive_word(64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF);
    drive_word(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    drive_word(64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE);
    drive_word(64'h0000_0000_0000_0002, 64'h7FFF_FFFF_FFFF_FFFF);
    drive_word(64'h0000_0000_0000_0000, 64'h8000_0000_0000_0001);

    // sender pauses until the pipe is empty
    wait_drained();

    random_phase(11, 73);
    random_phase(73, 11);

    // long receiver hold while the sender keeps offering: pipe fills up
    hold_toggle <= ~hold_toggle;
    random_phase(0, 0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.expected_words.size() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.expected_words.size()));
    end
    if (sb.error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- prime_product_word_mixer.f -----
rtl/core/ppwm_pkg.sv
rtl/core/prime_product_word_mixer.sv
sim/prime_product_word_mixer_tb.sv
